// ===== rtl/core/grid_line_cell_walker_macros.svh =====
// ----------------------------------------------------------------------------
// grid_line_cell_walker_macros: assertion helpers
// shared wrappers for clocked implication checks with a low-active reset
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_CELL_WALKER_MACROS_SVH
`define GRID_LINE_CELL_WALKER_MACROS_SVH

// same-cycle implication
`define GLCW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("glcw check failed");

// next-cycle implication
`define GLCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("glcw check failed");

`endif

// ===== rtl/core/glcw_pkg.sv =====
// ----------------------------------------------------------------------------
// glcw_pkg: shared types of the grid line cell walker
// fixed field widths and the segment job handed from front to back
// ----------------------------------------------------------------------------
package glcw_pkg;

    localparam int COORD_W = 13;   // raw coordinate
    localparam int DELTA_W = 14;   // signed coordinate difference
    localparam int CELL_W  = 5;    // cell index
    localparam int VAL_W   = 23;   // signed boundary offset, widest pitch
    localparam int PROD_W  = VAL_W + DELTA_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int CNT_W   = 6;    // emitted cell count

    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [CELL_W-1:0]        t_cell;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic  swapped;
        logic  backward;
        logic  up;
        t_cell major_cell;
        t_cell minor_cell;
        t_cell major_end;
        t_cell minor_end;
        t_cell cols_left;
        t_acc  cross_major;   // (major boundary - major origin) * minor delta
        t_acc  cross_minor;   // (minor origin - minor boundary) * |major delta|
        t_acc  cross_end;     // major term once the last column is reached
        t_acc  step_major;    // change of major term per column
        t_acc  step_minor;    // change of minor term per row
    } t_job;

endpackage

// ===== rtl/core/glcw_front.sv =====
// ----------------------------------------------------------------------------
// glcw_front: segment intake and setup
// clamps, finds cells and walk direction, forms crossing and step terms on one multiplier
// ----------------------------------------------------------------------------
module glcw_front
    import glcw_pkg::*;
#(
    parameter int GRID_CELLS    = 32,
    parameter int CELL_PITCH    = 16,
    parameter int FRACTION_BITS = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_coord i_start_x,
    input  t_coord i_start_y,
    input  t_coord i_end_x,
    input  t_coord i_end_y,
    output logic   o_push,
    input  logic   i_full,
    output t_job   o_job
);

    localparam int PITCH_RAW = CELL_PITCH * (1 << FRACTION_BITS);
    localparam int HALF_RAW  = PITCH_RAW / 2;
    localparam int COORD_MAX = GRID_CELLS * PITCH_RAW - HALF_RAW - 1;

    localparam logic signed [VAL_W-1:0] P_POS = VAL_W'(PITCH_RAW);
    localparam logic signed [VAL_W-1:0] P_NEG = VAL_W'(-PITCH_RAW);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CELL   = 3'd1;
    localparam logic [2:0] S_ORIENT = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_PUSH   = 3'd4;

    localparam logic [2:0] OP_MAJOR = 3'd0;
    localparam logic [2:0] OP_MINOR = 3'd1;
    localparam logic [2:0] OP_END   = 3'd2;
    localparam logic [2:0] OP_STEPA = 3'd3;
    localparam logic [2:0] OP_STEPB = 3'd4;

    logic [2:0] r_state, n_state;
    logic [2:0] r_op;

    t_coord r_sx, r_sy, r_ex, r_ey;
    t_cell  r_csx, r_csy, r_cex, r_cey;
    logic   r_swap;

    logic   r_bw, r_up;
    t_cell  r_mc, r_nc, r_mend, r_nend, r_cols;
    logic signed [VAL_W-1:0]   r_am, r_an;
    logic signed [DELTA_W-1:0] r_d, r_e, r_dabs;

    t_acc r_a0, r_b0, r_aend, r_sa, r_sb;

    function automatic t_coord clamp(input t_coord v);
        return (int'(v) > COORD_MAX) ? COORD_W'(COORD_MAX) : v;
    endfunction

    // thermometer of the cell edges, highest edge passed wins
    function automatic t_cell cell_of(input t_coord v);
        t_cell c;
        c = '0;
        for (int k = 1; k < GRID_CELLS; k++) begin
            if (int'(v) >= k * PITCH_RAW - HALF_RAW) begin
                c = CELL_W'(k);
            end
        end
        return c;
    endfunction

    // ---- cell stage ----
    logic w_swap;
    always_comb begin
        int dx;
        int dy;
        int adx;
        int ady;
        dx  = int'(r_ex) - int'(r_sx);
        dy  = int'(r_ey) - int'(r_sy);
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        w_swap = ady > adx;
    end

    // ---- orient stage ----
    logic   w_bw, w_up;
    t_cell  w_mc, w_nc, w_mend, w_nend, w_cols;
    logic signed [VAL_W-1:0]   w_am, w_an;
    logic signed [DELTA_W-1:0] w_d, w_e, w_dabs;

    always_comb begin
        int ma;
        int mb;
        int na;
        int nb;
        int d;
        int e;
        int mb0;
        int nb0;
        ma     = r_swap ? int'(r_sy) : int'(r_sx);
        mb     = r_swap ? int'(r_ey) : int'(r_ex);
        na     = r_swap ? int'(r_sx) : int'(r_sy);
        nb     = r_swap ? int'(r_ex) : int'(r_ey);
        w_mc   = r_swap ? r_csy : r_csx;
        w_mend = r_swap ? r_cey : r_cex;
        w_nc   = r_swap ? r_csx : r_csy;
        w_nend = r_swap ? r_cex : r_cey;
        d      = mb - ma;
        e      = (d < 0) ? (na - nb) : (nb - na);
        w_bw   = !(w_mc < w_mend);
        w_up   = w_nc < w_nend;
        w_cols = w_bw ? (w_mc - w_mend) : (w_mend - w_mc);
        // in the last column the crossing is the end point itself
        mb0    = (w_cols == '0) ? mb
               : int'(w_mc) * PITCH_RAW + (w_bw ? -HALF_RAW : HALF_RAW);
        nb0    = int'(w_nc) * PITCH_RAW + (w_up ? HALF_RAW : -HALF_RAW);
        w_am   = VAL_W'(mb0 - ma);
        w_an   = VAL_W'(na - nb0);
        w_d    = DELTA_W'(d);
        w_e    = DELTA_W'(e);
        w_dabs = DELTA_W'((d < 0) ? -d : d);
    end

    // ---- shared multiplier ----
    logic signed [VAL_W-1:0]   w_opa;
    logic signed [DELTA_W-1:0] w_opb;
    logic signed [PROD_W-1:0]  w_prod;

    always_comb begin
        case (r_op)
            OP_MAJOR: begin
                w_opa = r_am;
                w_opb = r_e;
            end
            OP_MINOR: begin
                w_opa = r_an;
                w_opb = r_dabs;
            end
            OP_END: begin
                w_opa = VAL_W'(r_d);
                w_opb = r_e;
            end
            OP_STEPA: begin
                w_opa = r_bw ? P_NEG : P_POS;
                w_opb = r_e;
            end
            OP_STEPB: begin
                w_opa = r_up ? P_NEG : P_POS;
                w_opb = r_dabs;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CELL;
            end
            S_CELL:   n_state = S_ORIENT;
            S_ORIENT: n_state = S_MUL;
            S_MUL: begin
                if (r_op == OP_STEPB) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_full) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_MAJOR;
        end else begin
            r_state <= n_state;
            if (r_state == S_ORIENT) begin
                r_op <= OP_MAJOR;
            end else if (r_state == S_MUL) begin
                r_op <= r_op + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_sx <= clamp(i_start_x);
            r_sy <= clamp(i_start_y);
            r_ex <= clamp(i_end_x);
            r_ey <= clamp(i_end_y);
        end
        if (r_state == S_CELL) begin
            r_csx  <= cell_of(r_sx);
            r_csy  <= cell_of(r_sy);
            r_cex  <= cell_of(r_ex);
            r_cey  <= cell_of(r_ey);
            r_swap <= w_swap;
        end
        if (r_state == S_ORIENT) begin
            r_bw   <= w_bw;
            r_up   <= w_up;
            r_mc   <= w_mc;
            r_nc   <= w_nc;
            r_mend <= w_mend;
            r_nend <= w_nend;
            r_cols <= w_cols;
            r_am   <= w_am;
            r_an   <= w_an;
            r_d    <= w_d;
            r_e    <= w_e;
            r_dabs <= w_dabs;
        end
        if (r_state == S_MUL) begin
            case (r_op)
                OP_MAJOR: r_a0   <= ACC_W'(w_prod);
                OP_MINOR: r_b0   <= ACC_W'(w_prod);
                OP_END:   r_aend <= ACC_W'(w_prod);
                OP_STEPA: r_sa   <= ACC_W'(w_prod);
                OP_STEPB: r_sb   <= ACC_W'(w_prod);
                default:  r_sb   <= r_sb;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_push  = (r_state == S_PUSH) && !i_full;

    always_comb begin
        o_job.swapped     = r_swap;
        o_job.backward    = r_bw;
        o_job.up          = r_up;
        o_job.major_cell  = r_mc;
        o_job.minor_cell  = r_nc;
        o_job.major_end   = r_mend;
        o_job.minor_end   = r_nend;
        o_job.cols_left   = r_cols;
        o_job.cross_major = r_a0;
        o_job.cross_minor = r_b0;
        o_job.cross_end   = r_aend;
        o_job.step_major  = r_sa;
        o_job.step_minor  = r_sb;
    end

endmodule

// ===== rtl/core/glcw_queue.sv =====
// ----------------------------------------------------------------------------
// glcw_queue: two-entry job queue
// decouples segment setup from the cell walk
// ----------------------------------------------------------------------------
module glcw_queue
    import glcw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

endmodule

// ===== rtl/core/glcw_walk.sv =====
// ----------------------------------------------------------------------------
// glcw_walk: cell walker
// one covered cell per cycle into an output register while the output is not stalled, exact crossing tests
// ----------------------------------------------------------------------------
module glcw_walk
    import glcw_pkg::*;
#(
    parameter int GRID_CELLS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_job_valid,
    input  t_job  i_job,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_cell o_col,
    output t_cell o_row,
    output logic  o_last
);

    localparam logic [CNT_W-1:0] LAST_N = CNT_W'(2 * GRID_CELLS - 2);

    logic r_busy;
    logic r_out_valid;
    logic [CNT_W-1:0] r_n;

    logic  r_sw, r_bw, r_up;
    t_cell r_mc, r_nc, r_mend, r_nend, r_cols;
    t_acc  r_a, r_b, r_a_end, r_step_a, r_step_b;
    t_cell r_col, r_row;
    logic  r_last;

    logic w_adv;
    logic w_fin;
    logic w_row_end;
    logic w_major;
    t_acc w_f;
    t_acc w_a_next;
    t_acc w_b_next;

    assign o_pop = !r_busy && i_job_valid;
    assign w_adv = r_busy && (!r_out_valid || i_ready);

    always_comb begin
        w_row_end = (r_nc == r_nend);
        w_fin     = ((r_mc == r_mend) && w_row_end) || (r_n == LAST_N);
        w_f       = r_a + r_b;
        // strict below the upper edge when going up, strict above going down
        if (r_up) begin
            w_major = w_f[ACC_W-1];
        end else begin
            w_major = (!w_f[ACC_W-1] && (w_f != '0)) || w_row_end;
        end
        if (w_major && (r_cols == '0)) w_major = 1'b0;
        if (!w_major && w_row_end)     w_major = 1'b1;
        w_a_next = (r_cols == CELL_W'(1)) ? r_a_end : (r_a + r_step_a);
        w_b_next = r_b + r_step_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_n         <= '0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (w_adv) begin
                if (w_fin) r_busy <= 1'b0;
                r_n <= r_n + CNT_W'(1);
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sw     <= i_job.swapped;
            r_bw     <= i_job.backward;
            r_up     <= i_job.up;
            r_mc     <= i_job.major_cell;
            r_nc     <= i_job.minor_cell;
            r_mend   <= i_job.major_end;
            r_nend   <= i_job.minor_end;
            r_cols   <= i_job.cols_left;
            r_a      <= i_job.cross_major;
            r_b      <= i_job.cross_minor;
            r_a_end  <= i_job.cross_end;
            r_step_a <= i_job.step_major;
            r_step_b <= i_job.step_minor;
        end else if (w_adv && !w_fin) begin
            if (w_major) begin
                r_cols <= r_cols - CELL_W'(1);
                r_mc   <= r_bw ? (r_mc - CELL_W'(1)) : (r_mc + CELL_W'(1));
                r_a    <= w_a_next;
            end else begin
                r_nc <= r_up ? (r_nc + CELL_W'(1)) : (r_nc - CELL_W'(1));
                r_b  <= w_b_next;
            end
        end
        if (w_adv) begin
            r_col  <= r_sw ? r_nc : r_mc;
            r_row  <= r_sw ? r_mc : r_nc;
            r_last <= w_fin;
        end
    end

    assign o_valid = r_out_valid;
    assign o_col   = r_col;
    assign o_row   = r_row;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/grid_line_cell_walker.sv =====
// ----------------------------------------------------------------------------
// grid_line_cell_walker: supercover cell walk of a 2-d segment
// input beat on s_axis: one segment, tdata = start_x, start_y, end_x, end_y
// (13 bits each, 4 fraction bits by default), clamped to the grid
// output beats on m_axis: every covered cell as column and row, tlast on the
// segment's final cell; a segment inside one cell gives a single beat
// front setup per segment: cell search, orientation, five products on one shared
// multiplier, queue push; a 2-entry queue then feeds the walker, which loads a
// job and then gives one covered cell per cycle while m_axis is not stalled;
// the front takes one segment at a time and sets up the next one while the
// walker works on the last; a segment covers up to 63 cells
// a stalled m_axis holds its beat in the output register and freezes the walk;
// the queue then fills and s_axis_tready drops
// reset (i_rst_n low, synchronous) empties the queue and idles both parts
// ----------------------------------------------------------------------------
`include "grid_line_cell_walker_macros.svh"

module grid_line_cell_walker
    import glcw_pkg::*;
#(
    parameter int GRID_CELLS    = 32,
    parameter int CELL_PITCH    = 16,
    parameter int FRACTION_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // start_x, start_y, end_x, end_y, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cell_col, cell_row, zero pad
    output logic        m_axis_tlast
);

    // front to queue
    logic w_push;
    logic w_q_full;
    t_job w_front_job;

    // queue to walker
    logic w_pop;
    logic w_q_empty;
    t_job w_q_job;

    t_cell w_col;
    t_cell w_row;

    glcw_front #(
        .GRID_CELLS    (GRID_CELLS),
        .CELL_PITCH    (CELL_PITCH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_start_x (s_axis_tdata[12:0]),
        .i_start_y (s_axis_tdata[25:13]),
        .i_end_x   (s_axis_tdata[38:26]),
        .i_end_y   (s_axis_tdata[51:39]),
        .o_push    (w_push),
        .i_full    (w_q_full),
        .o_job     (w_front_job)
    );

    // jobs wait here while the walker is busy with a long segment
    glcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_empty (w_q_empty),
        .o_job   (w_q_job)
    );

    glcw_walk #(
        .GRID_CELLS (GRID_CELLS)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_q_empty),
        .i_job       (w_q_job),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_col       (w_col),
        .o_row       (w_row),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, w_row, w_col};

    // front takes one segment at a time, busy right after a beat
    `GLCW_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // a pushed job is visible to the walker next cycle
    `GLCW_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push, !w_q_empty)
    // walker only loads a job that is there
    `GLCW_ASSERT_NOW(a_pop_valid, i_clk, i_rst_n, w_pop, !w_q_empty)

endmodule

// ===== verif/grid_line_cell_walker_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_line_cell_walker_test: self-checking bench for the grid cell walker
// segments go in on s_axis, covered cells come back on m_axis; a scoreboard
// walks every accepted segment itself and checks each returned cell in order
// ----------------------------------------------------------------------------
module grid_line_cell_walker_test;
    import glcw_pkg::*;

    localparam int    GRID_CELLS    = 32;
    localparam int    CELL_PITCH    = 16;
    localparam int    FRACTION_BITS = 4;
    localparam int    PITCH_RAW     = CELL_PITCH << FRACTION_BITS;
    localparam int    HALF_RAW      = PITCH_RAW / 2;
    localparam int    COORD_MAX     = GRID_CELLS * PITCH_RAW - HALF_RAW - 1;
    localparam int    MAX_CELLS     = 2 * GRID_CELLS - 1;
    localparam int    CYCLE_LIMIT   = 1_000_000;
    localparam int    RANDOM_ITEMS  = 185;

    // one covered cell as it should leave the block
    typedef struct packed {
        t_cell col;
        t_cell row;
        logic  is_last;
    } cell_beat_t;

    // shapes of random segments
    typedef enum int {
        SEG_WIDE,
        SEG_SHORT,
        SEG_ON_EDGES,
        SEG_AXIS,
        SEG_DIAGONAL,
        SEG_OFF_GRID,
        SEG_IN_CELL
    } seg_shape_e;

    // ------------------------------------------------------------------------
    // scoreboard: walks each accepted segment and keeps the cells still owed
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        cell_beat_t cells_due[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        // saturate a raw coordinate to the last point inside the grid
        static function longint clamp_raw(t_coord v);
            return (longint'(v) > COORD_MAX) ? longint'(COORD_MAX) : longint'(v);
        endfunction

        // cells are centred on multiples of the pitch
        static function longint cell_index(longint v);
            return (v + HALF_RAW) / PITCH_RAW;
        endfunction

        static function longint mag(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function int outstanding();
            return cells_due.size();
        endfunction

        // supercover walk of one segment, exact integer crossing tests
        function void note_segment(t_coord sx_raw, t_coord sy_raw,
                                   t_coord ex_raw, t_coord ey_raw);
            longint     sx, sy, ex, ey;
            longint     ma, mb, na, nb, mend, nend, dmaj, dabs, emin;
            longint     maj, mnr, cols, maj_edge, mnr_edge, bias;
            bit         swapped, backward, up, fin, take_major;
            cell_beat_t beat;
            sx = clamp_raw(sx_raw);
            sy = clamp_raw(sy_raw);
            ex = clamp_raw(ex_raw);
            ey = clamp_raw(ey_raw);
            swapped = mag(ey - sy) > mag(ex - sx);
            ma   = swapped ? sy : sx;
            mb   = swapped ? ey : ex;
            na   = swapped ? sx : sy;
            nb   = swapped ? ex : ey;
            mend = cell_index(mb);
            nend = cell_index(nb);
            dmaj = mb - ma;
            dabs = mag(dmaj);
            emin = (dmaj < 0) ? -(nb - na) : (nb - na);
            maj  = cell_index(ma);
            mnr  = cell_index(na);
            backward = !(maj < mend);
            up       = mnr < nend;
            cols     = mag(mend - maj);
            // far edge of the current column, or the end point in the last one
            maj_edge = (cols == 0) ? mb : maj * PITCH_RAW + (backward ? -HALF_RAW : HALF_RAW);
            mnr_edge = mnr * PITCH_RAW + (up ? HALF_RAW : -HALF_RAW);
            for (int n = 0; n < MAX_CELLS; n++) begin
                fin = (maj == mend && mnr == nend) || n == MAX_CELLS - 1;
                beat.col     = t_cell'(swapped ? mnr : maj);
                beat.row     = t_cell'(swapped ? maj : mnr);
                beat.is_last = fin;
                cells_due.push_back(beat);
                if (fin) break;
                // sign of (minor crossing at the column edge - row edge) * |d|
                bias = na * dabs + (maj_edge - ma) * emin - mnr_edge * dabs;
                if (up) take_major = bias < 0;
                else    take_major = bias > 0 || mnr == nend;
                if (take_major && cols == 0) take_major = 1'b0;
                if (!take_major && mnr == nend) take_major = 1'b1;
                if (take_major) begin
                    cols = cols - 1;
                    maj  = maj + (backward ? -1 : 1);
                    maj_edge = (cols == 0) ? mb
                             : maj_edge + (backward ? -PITCH_RAW : PITCH_RAW);
                end else begin
                    mnr      = mnr + (up ? 1 : -1);
                    mnr_edge = mnr_edge + (up ? PITCH_RAW : -PITCH_RAW);
                end
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("%0t ns: %s", $time, what);
        endtask

        task check_cell(t_cell col, t_cell row, logic is_last);
            cell_beat_t want;
            if (cells_due.size() == 0) begin
                report($sformatf("unexpected cell (%0d,%0d) last=%0b", col, row, is_last));
                return;
            end
            want = cells_due.pop_front();
            if (col !== want.col)
                report($sformatf("column got %0d want %0d", col, want.col));
            if (row !== want.row)
                report($sformatf("row got %0d want %0d", row, want.row));
            if (is_last !== want.is_last)
                report($sformatf("last got %0b want %0b", is_last, want.is_last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;    // start_x, start_y, end_x, end_y, zero pad
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // cell_col, cell_row, zero pad
    logic        m_axis_tlast;

    grid_line_cell_walker #(
        .GRID_CELLS    (GRID_CELLS),
        .CELL_PITCH    (CELL_PITCH),
        .FRACTION_BITS (FRACTION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    cell_scoreboard book;
    bit             idle_on      = 1'b1;   // random gaps on both sides
    int             stall_cycles = 0;      // one-shot long hold-off for the receiver
    int             cycle_count  = 0;

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender side: every call starts and ends just after a falling edge
    // ------------------------------------------------------------------------
    task automatic send_segment(input t_coord sx, input t_coord sy,
                                input t_coord ex, input t_coord ey);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {4'b0, ey, ex, sy, sx};
        s_axis_tvalid = 1'b1;
        // beat accepted on the rising edge with tready high
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_segment(sx, sy, ex, ey);
        @(negedge i_clk);
    endtask

    // sender pause until every owed cell is back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (book.outstanding() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // keeps a coordinate on the grid
    function automatic t_coord fit(int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return t_coord'(COORD_MAX);
        return t_coord'(v);
    endfunction

    task automatic send_random();
        seg_shape_e shape;
        int         draw, len, sx, sy, ex, ey;
        draw  = $urandom_range(0, 9);
        shape = (draw > 6) ? SEG_SHORT : seg_shape_e'(draw);
        sx = $urandom_range(0, COORD_MAX);
        sy = $urandom_range(0, COORD_MAX);
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
        case (shape)
            SEG_WIDE: begin
                // all 13 bits free for sx and ey, the outer columns and top rows clamp
                sx = $urandom_range(0, 8191);
                ey = $urandom_range(0, 8191);
            end
            SEG_SHORT: begin
                ex = fit(sx + $urandom_range(0, 1200) - 600);
                ey = fit(sy + $urandom_range(0, 1200) - 600);
            end
            SEG_ON_EDGES: begin
                // cell edges and centres, where crossings tie
                sx = $urandom_range(0, 62) * HALF_RAW;
                sy = $urandom_range(0, 62) * HALF_RAW;
                ex = fit($urandom_range(0, 62) * HALF_RAW + $urandom_range(0, 2) - 1);
                ey = $urandom_range(0, 62) * HALF_RAW;
            end
            SEG_AXIS: begin
                if ($urandom_range(0, 1)) ey = sy;
                else                      ex = sx;
            end
            SEG_DIAGONAL: begin
                len = $urandom_range(0, 3000);
                ex  = $urandom_range(0, 1) ? fit(sx + len) : fit(sx - len);
                ey  = $urandom_range(0, 1) ? sy + (ex - sx) : sy - (ex - sx);
                ey  = fit(ey);
            end
            SEG_OFF_GRID: begin
                sy = $urandom_range(COORD_MAX + 1, 8191);
                ex = $urandom_range(COORD_MAX + 1, 8191);
            end
            default: begin
                // both ends in one cell
                sx = $urandom_range(0, GRID_CELLS - 1) * PITCH_RAW;
                sy = $urandom_range(0, GRID_CELLS - 1) * PITCH_RAW;
                ex = fit(sx + $urandom_range(0, PITCH_RAW - 1) - HALF_RAW);
                ey = fit(sy + $urandom_range(0, PITCH_RAW - 1) - HALF_RAW);
            end
        endcase
        send_segment(t_coord'(sx), t_coord'(sy), t_coord'(ex), t_coord'(ey));
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random gap per beat, plus the long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 14) : 0;
            if (stall_cycles > 0) begin
                gap          = gap + stall_cycles;
                stall_cycles = 0;
            end
            if (gap > 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            book.check_cell(m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tlast);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        book          = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: single cells, both grid corners
        send_segment(13'd100, 13'd100, 13'd120, 13'd90);
        send_segment(13'd0, 13'd0, 13'd0, 13'd0);
        send_segment(13'd8063, 13'd8063, 13'd8063, 13'd8063);
        // full diagonals hit a corner tie in every cell, longest walks
        send_segment(13'd0, 13'd0, 13'd8063, 13'd8063);
        send_segment(13'd8063, 13'd8063, 13'd0, 13'd0);
        send_segment(13'd0, 13'd8063, 13'd8063, 13'd0);
        send_segment(13'd8063, 13'd0, 13'd0, 13'd8063);
        send_segment(13'd0, 13'd0, 13'd8063, 13'd8062);
        // straight runs along each axis, forward and backward
        send_segment(13'd0, 13'd1000, 13'd8063, 13'd1000);
        send_segment(13'd8063, 13'd4000, 13'd0, 13'd4000);
        send_segment(13'd500, 13'd0, 13'd500, 13'd8063);
        send_segment(13'd7000, 13'd8063, 13'd7000, 13'd0);
        // coordinates past the grid are saturated
        send_segment(13'd8191, 13'd8191, 13'd8064, 13'd0);
        send_segment(13'd0, 13'd8191, 13'd8191, 13'd0);
        // lying on a row's lower edge, walking down onto one
        send_segment(13'd0, 13'd896, 13'd4000, 13'd896);
        send_segment(13'd0, 13'd1000, 13'd8000, 13'd640);
        // start and end share the major cell but not the minor one
        send_segment(13'd130, 13'd120, 13'd380, 13'd140);
        send_segment(13'd120, 13'd380, 13'd140, 13'd130);
        // steep and shallow, crossing exact cell edges
        send_segment(13'd128, 13'd0, 13'd640, 13'd512);
        send_segment(13'd3000, 13'd6000, 13'd2900, 13'd200);
        send_segment(13'd5461, 13'd2730, 13'd4095, 13'd6827);
        drain();

        // hold the receiver off while segments keep coming: queue fills
        stall_cycles = 400;
        for (int i = 0; i < 14; i++) send_random();
        drain();

        // random part, one stretch with no idling on either side
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) idle_on = (i / 40 != 2);
            if (i == 150) drain();
            send_random();
        end
        idle_on = 1'b1;
        drain();

        // let any stray beat show up
        repeat (80) @(posedge i_clk);
        if (book.errors == 0 && book.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
